/* hdl/drmt_pkg.sv */
// ----------------------------------------------------------------------------
// drmt_pkg
// Shared codes, widths and defaults for the dual response matcher with timeout.
// ----------------------------------------------------------------------------
`default_nettype none

package drmt_pkg;

  // pattern size default (bytes)
  localparam int MAX_PATTERN_DEF = 8;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 4;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 2;
  localparam int VERDICT_W = 2;

  // input item kinds
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_PASS    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FAIL    = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PASS_PATTERN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_PATTERN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;

  // register reset values
  localparam logic [LEN_W-1:0]  PASS_LENGTH_RST   = 4'd1;
  localparam logic [LEN_W-1:0]  FAIL_LENGTH_RST   = 4'd0;
  localparam logic [TIME_W-1:0] TIMEOUT_TICKS_RST = 32'd1000;

endpackage

`default_nettype wire

/* hdl/drmt_track.sv */
// ----------------------------------------------------------------------------
// drmt_track
// One pattern tracker: compares a byte with the next expected pattern byte and
// returns the new index and whether the pattern just completed.
// ----------------------------------------------------------------------------
`default_nettype none

module drmt_track #(
  parameter int MAX_PATTERN = drmt_pkg::MAX_PATTERN_DEF
) (
  input  wire logic [8*MAX_PATTERN-1:0]               pattern,
  input  wire logic [drmt_pkg::LEN_W-1:0]             length,
  input  wire logic [$clog2(MAX_PATTERN+1)-1:0]       idx,
  input  wire logic [drmt_pkg::BYTE_W-1:0]            rx_byte,
  output logic      [$clog2(MAX_PATTERN+1)-1:0]       idx_next,
  output logic                                        done
);
  import drmt_pkg::*;

  localparam int IW = $clog2(MAX_PATTERN + 1);
  localparam int SW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [BYTE_W-1:0] pat_bytes [MAX_PATTERN];
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  idx_w;
  logic [LEN_W-1:0]  idx_inc;
  logic [SW-1:0]     sel;
  logic              hit;

  // split the pattern into bytes
  always_comb begin
    for (int b = 0; b < MAX_PATTERN; b++) begin
      pat_bytes[b] = pattern[b*BYTE_W +: BYTE_W];
    end
  end

  // clamp length to the pattern size
  assign eff_len = (length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : length;

  assign idx_w   = LEN_W'(idx);
  assign idx_inc = idx_w + 1'b1;
  assign sel     = idx[SW-1:0];

  // index at or past the length counts as a mismatch
  assign hit = (eff_len != '0) && (idx_w < eff_len) && (rx_byte == pat_bytes[sel]);

  // advance on a hit, otherwise back to zero without re-testing
  always_comb begin
    if (hit) begin
      idx_next = IW'(idx_inc);
      done     = (idx_inc == eff_len);
    end else begin
      idx_next = '0;
      done     = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hdl/dual_response_matcher_timeout_unit.sv */
// ----------------------------------------------------------------------------
// dual_response_matcher_timeout_unit
// Pass / fail byte-pattern matcher with a millisecond timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the item kind (byte, tick, start), tdata the
//   received byte. A start item arms the matcher and clears both indices and
//   the elapsed counter. Bytes advance the pass and fail trackers, ticks count
//   elapsed time. The block emits one verdict (pass, fail, timeout) on the
//   output stream and goes idle; other items produce no output.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wdata while
//   the block is idle; writes to unknown indexes are dropped.
//   A verdict passes through the input register, then the result register.
//   Throughput: one item per cycle while a verdict can enter the result register;
//   the tracker and timer update between the two registers is combinational.
//   Reset clears the input stage, the output register, the matcher state and
//   the configuration registers to their defaults.
//   When the receiver stalls the verdict is held; the input register still
//   takes one more item, and items that yield no verdict keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_response_matcher_timeout_unit #(
  parameter int MAX_PATTERN = drmt_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_wr_en,
  input  wire logic [drmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [drmt_pkg::CFG_W-1:0]        cfg_wdata,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]                        s_axis_tuser,   // [1:0] op
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [7:0]                        m_axis_tdata    // [1:0] verdict
);
  import drmt_pkg::*;

  localparam int PW = 8 * MAX_PATTERN;
  localparam int IW = $clog2(MAX_PATTERN + 1);

  // configuration registers
  logic [PW-1:0]     pass_pattern;
  logic [LEN_W-1:0]  pass_length;
  logic [PW-1:0]     fail_pattern;
  logic [LEN_W-1:0]  fail_length;
  logic [TIME_W-1:0] timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_pattern  <= '0;
      pass_length   <= PASS_LENGTH_RST;
      fail_pattern  <= '0;
      fail_length   <= FAIL_LENGTH_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PASS_PATTERN:  pass_pattern  <= cfg_wdata[PW-1:0];
        REG_PASS_LENGTH:   pass_length   <= cfg_wdata[LEN_W-1:0];
        REG_FAIL_PATTERN:  fail_pattern  <= cfg_wdata[PW-1:0];
        REG_FAIL_LENGTH:   fail_length   <= cfg_wdata[LEN_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              stage_valid;
  logic [OP_W-1:0]   stage_op;
  logic [BYTE_W-1:0] stage_byte;
  logic              stage_fire;
  logic              in_xfer;

  assign s_axis_tready = !stage_valid || stage_fire;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_xfer) begin
      stage_valid <= 1'b1;
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_op   <= s_axis_tuser[OP_W-1:0];
      stage_byte <= s_axis_tdata[BYTE_W-1:0];
    end
  end

  // matcher state
  logic              waiting;
  logic [IW-1:0]     pass_index;
  logic [IW-1:0]     fail_index;
  logic [TIME_W-1:0] elapsed;

  logic [IW-1:0]     pass_idx_trk;
  logic [IW-1:0]     fail_idx_trk;
  logic              pass_done;
  logic              fail_done;

  drmt_track #(.MAX_PATTERN(MAX_PATTERN)) u_pass (
    .pattern  (pass_pattern),
    .length   (pass_length),
    .idx      (pass_index),
    .rx_byte  (stage_byte),
    .idx_next (pass_idx_trk),
    .done     (pass_done)
  );

  drmt_track #(.MAX_PATTERN(MAX_PATTERN)) u_fail (
    .pattern  (fail_pattern),
    .length   (fail_length),
    .idx      (fail_index),
    .rx_byte  (stage_byte),
    .idx_next (fail_idx_trk),
    .done     (fail_done)
  );

  // next state and verdict for the staged item
  logic              waiting_next;
  logic [IW-1:0]     pass_index_next;
  logic [IW-1:0]     fail_index_next;
  logic [TIME_W-1:0] elapsed_next;
  logic              produce;
  logic [VERDICT_W-1:0] verdict_next;

  always_comb begin
    waiting_next    = waiting;
    pass_index_next = pass_index;
    fail_index_next = fail_index;
    elapsed_next    = elapsed;
    produce         = 1'b0;
    verdict_next    = VERDICT_PASS;
    case (stage_op)
      OP_START: begin
        waiting_next    = 1'b1;
        pass_index_next = '0;
        fail_index_next = '0;
        elapsed_next    = '0;
      end
      OP_BYTE: begin
        if (waiting) begin
          pass_index_next = pass_idx_trk;
          if (pass_done) begin
            // pass has priority; fail tracker is left untouched
            waiting_next = 1'b0;
            produce      = 1'b1;
            verdict_next = VERDICT_PASS;
          end else begin
            fail_index_next = fail_idx_trk;
            if (fail_done) begin
              waiting_next = 1'b0;
              produce      = 1'b1;
              verdict_next = VERDICT_FAIL;
            end
          end
        end
      end
      OP_TICK: begin
        if (waiting) begin
          if (elapsed < timeout_ticks) begin
            elapsed_next = elapsed + 1'b1;
          end
          if (elapsed_next >= timeout_ticks) begin
            waiting_next = 1'b0;
            produce      = 1'b1;
            verdict_next = VERDICT_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  // staged item moves on unless its verdict would hit a full output register
  assign stage_fire = stage_valid && (!produce || !m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting    <= 1'b0;
      pass_index <= '0;
      fail_index <= '0;
      elapsed    <= '0;
    end else if (stage_fire) begin
      waiting    <= waiting_next;
      pass_index <= pass_index_next;
      fail_index <= fail_index_next;
      elapsed    <= elapsed_next;
    end
  end

  // result register
  logic [VERDICT_W-1:0] verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (stage_fire && produce) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && produce) begin
      verdict <= verdict_next;
    end
  end

  assign m_axis_tdata = {{(8 - VERDICT_W){1'b0}}, verdict};

endmodule

`default_nettype wire

/* hdl/drmt_checker.sv */
// ----------------------------------------------------------------------------
// drmt_checker
// Port-level checks for the dual response matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drmt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);
  import drmt_pkg::*;

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // only the three verdict codes, upper bits zero
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == VERDICT_PASS ||
                       m_axis_tdata[1:0] == VERDICT_FAIL ||
                       m_axis_tdata[1:0] == VERDICT_TIMEOUT) &&
                      (m_axis_tdata[7:2] == 6'd0))
    else $error("bad verdict code");

  // input side never blocks while the output side is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with output free");

  // stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled verdict changed");

endmodule

bind dual_response_matcher_timeout_unit drmt_checker u_drmt_checker (.*);

`default_nettype wire

/* bench/drmt_verdict_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drmt_verdict_checker
// Watches the configuration port and both streams of the pass / fail matcher,
// keeps its own copy of the matcher state, predicts every verdict and compares
// each output transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module drmt_verdict_checker
  import drmt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]           s_axis_tuser,   // [1:0] op
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [7:0]           m_axis_tdata,   // [1:0] verdict
  output int                   mismatches,
  output int                   pending,
  output int                   live_items,
  output int                   pass_count,
  output int                   fail_count,
  output int                   timeout_count
);

  // shadow copy of the configuration registers
  logic [CFG_W-1:0]  pass_pat;
  logic [CFG_W-1:0]  fail_pat;
  logic [LEN_W-1:0]  pass_len;
  logic [LEN_W-1:0]  fail_len;
  logic [TIME_W-1:0] limit_ticks;

  // shadow matcher state
  logic              armed;
  logic [LEN_W-1:0]  pass_pos;
  logic [LEN_W-1:0]  fail_pos;
  logic [TIME_W-1:0] ms_elapsed;

  // verdicts predicted but not yet seen on the output stream
  logic [VERDICT_W-1:0] verdict_q[$];

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    mismatches++;
  endtask

  // next tracker position after one byte; zero on mismatch, no retest
  function automatic logic [LEN_W-1:0] next_pos(input logic [CFG_W-1:0] pat,
                                                input logic [LEN_W-1:0] len_reg,
                                                input logic [LEN_W-1:0] pos,
                                                input logic [7:0]       rx);
    logic [LEN_W-1:0] len;
    len = (len_reg > MAX_PATTERN_DEF) ? LEN_W'(MAX_PATTERN_DEF) : len_reg;
    if (len == 0) return '0;
    if (pos < len && pat[{pos[2:0], 3'b000} +: 8] == rx) return pos + 1'b1;
    return '0;
  endfunction

  // one accepted input item
  task automatic predict_item(input logic [1:0] op, input logic [7:0] rx);
    if (op == OP_START || (armed && (op == OP_BYTE || op == OP_TICK))) live_items++;
    case (op)
      OP_START: begin
        armed      = 1'b1;
        pass_pos   = '0;
        fail_pos   = '0;
        ms_elapsed = '0;
      end
      OP_BYTE: begin
        if (armed) begin
          // pass is tested first; fail tracker untouched when pass completes
          pass_pos = next_pos(pass_pat, pass_len, pass_pos, rx);
          if (pass_pos != 0 && pass_pos == pass_len) begin
            armed = 1'b0;
            verdict_q.push_back(VERDICT_PASS);
          end else if (pass_pos != 0 && pass_len > MAX_PATTERN_DEF &&
                       pass_pos == LEN_W'(MAX_PATTERN_DEF)) begin
            armed = 1'b0;
            verdict_q.push_back(VERDICT_PASS);
          end else begin
            fail_pos = next_pos(fail_pat, fail_len, fail_pos, rx);
            if (fail_pos != 0 && (fail_pos == fail_len || (fail_len > MAX_PATTERN_DEF &&
                fail_pos == LEN_W'(MAX_PATTERN_DEF)))) begin
              armed = 1'b0;
              verdict_q.push_back(VERDICT_FAIL);
            end
          end
        end
      end
      OP_TICK: begin
        if (armed) begin
          if (ms_elapsed < limit_ticks) ms_elapsed++;
          if (ms_elapsed >= limit_ticks) begin
            armed = 1'b0;
            verdict_q.push_back(VERDICT_TIMEOUT);
          end
        end
      end
      default: ;
    endcase
  endtask

  // one output transfer against the oldest prediction
  task automatic check_verdict(input logic [7:0] word);
    logic [VERDICT_W-1:0] want;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("verdict %0d with nothing outstanding", word[1:0]));
      return;
    end
    want = verdict_q.pop_front();
    if (word[VERDICT_W-1:0] !== want)
      report_mismatch($sformatf("verdict %0d, predicted %0d", word[VERDICT_W-1:0], want));
    if (word[7:VERDICT_W] !== '0)
      report_mismatch($sformatf("tdata padding 0x%02h not zero", word));
    case (want)
      VERDICT_PASS:    pass_count++;
      VERDICT_FAIL:    fail_count++;
      VERDICT_TIMEOUT: timeout_count++;
      default: ;
    endcase
  endtask

  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_PASS_PATTERN:  pass_pat    = val;
      REG_PASS_LENGTH:   pass_len    = val[LEN_W-1:0];
      REG_FAIL_PATTERN:  fail_pat    = val;
      REG_FAIL_LENGTH:   fail_len    = val[LEN_W-1:0];
      REG_TIMEOUT_TICKS: limit_ticks = val[TIME_W-1:0];
      default: ;
    endcase
  endtask

  // output side first: a verdict leaving now belongs to an earlier item
  always @(posedge clk) begin
    if (rst) begin
      pass_pat      = '0;
      fail_pat      = '0;
      pass_len      = PASS_LENGTH_RST;
      fail_len      = FAIL_LENGTH_RST;
      limit_ticks   = TIMEOUT_TICKS_RST;
      armed         = 1'b0;
      pass_pos      = '0;
      fail_pos      = '0;
      ms_elapsed    = '0;
      verdict_q.delete();
      pending       = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_verdict(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
      if (cfg_wr_en) load_reg(cfg_index, cfg_wdata);
      pending = verdict_q.size();
    end
  end

endmodule

/* bench/dual_response_matcher_timeout_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_response_matcher_timeout_unit_tb
// Drives the matcher with directed and random byte / tick / start streams
// under a series of pattern, length and timeout settings, with random gaps
// on the input and random stalls on the output; the verdict checker predicts
// and compares every result.
// ----------------------------------------------------------------------------

module dual_response_matcher_timeout_unit_tb;
  import drmt_pkg::*;

  localparam int ITEM_TARGET = 1900;
  localparam int SETTLE      = 4;

  // item kind outside the defined set, must be ignored
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] rx_byte
  logic [1:0]           s_axis_tuser;   // [1:0] op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // [1:0] verdict

  int mismatches, pending, live_items, pass_count, fail_count, timeout_count;
  int sent;
  int phases;
  bit calm;

  // settings of the current phase, kept for building bursts
  logic [CFG_W-1:0] pass_pat, fail_pat;
  logic [LEN_W-1:0] pass_len, fail_len;
  logic [7:0]       alpha [3];

  dual_response_matcher_timeout_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  drmt_verdict_checker u_verdict_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .live_items    (live_items),
    .pass_count    (pass_count),
    .fail_count    (fail_count),
    .timeout_count (timeout_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("dual_response_matcher_timeout_unit_tb: errors");
    $finish;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side: random stalls
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] rx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= rx;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // hold input until every predicted verdict has left, then let the pipe settle
  task automatic wait_idle(input int settle);
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    do begin
      @(negedge clk);
      guard++;
    end while (pending != 0 && guard < 5000);
    // back on the rising edge before driving again
    @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // full register set; lengths and timeout carry junk in the unused upper bits
  task automatic write_config(input logic [CFG_W-1:0] pp, input logic [LEN_W-1:0] pl,
                              input logic [CFG_W-1:0] fp, input logic [LEN_W-1:0] fl,
                              input logic [TIME_W-1:0] tout);
    logic [CFG_W-1:0] junk;
    pass_pat = pp;
    pass_len = pl;
    fail_pat = fp;
    fail_len = fl;
    write_reg(REG_PASS_PATTERN, pp);
    junk = {$urandom, $urandom};
    junk[LEN_W-1:0] = pl;
    write_reg(REG_PASS_LENGTH, junk);
    write_reg(REG_FAIL_PATTERN, fp);
    junk = {$urandom, $urandom};
    junk[LEN_W-1:0] = fl;
    write_reg(REG_FAIL_LENGTH, junk);
    junk = {$urandom, $urandom};
    junk[TIME_W-1:0] = tout;
    write_reg(REG_TIMEOUT_TICKS, junk);
    // unmapped index now and then, must be dropped
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_TIMEOUT_TICKS + 1, 2**CFG_IDX_W - 1)),
                {$urandom, $urandom});
    cfg_wr_en <= 1'b0;
    phases++;
  endtask

  // leading bytes of a pattern, sometimes with one corrupted bit
  task automatic send_burst(input logic [CFG_W-1:0] pat, input logic [LEN_W-1:0] len_reg);
    int eff, cnt, bad;
    logic [7:0] rx;
    eff = (len_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len_reg;
    if (eff == 0) begin
      send_item(OP_BYTE, pat[7:0]);
      return;
    end
    cnt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, eff) : eff;
    bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cnt - 1) : -1;
    for (int i = 0; i < cnt; i++) begin
      rx = pat[i*8 +: 8];
      if (i == bad) rx = rx ^ (8'd1 << $urandom_range(0, 7));
      send_item(OP_BYTE, rx);
    end
  endtask

  function automatic logic [CFG_W-1:0] make_pattern();
    logic [CFG_W-1:0] pat;
    for (int i = 0; i < 8; i++)
      pat[i*8 +: 8] = ($urandom_range(0, 9) < 7) ? alpha[$urandom_range(0, 2)]
                                                  : 8'($urandom_range(0, 255));
    return pat;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return LEN_W'($urandom_range(1, MAX_PATTERN_DEF));
    if (r < 88) return '0;
    return LEN_W'($urandom_range(MAX_PATTERN_DEF + 1, 2**LEN_W - 1));
  endfunction

  function automatic logic [TIME_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return TIME_W'($urandom_range(1, 40));
    if (r < 80) return '0;
    if (r < 90) return '1;
    return TIME_W'($urandom);
  endfunction

  // one armed sequence of random content
  task automatic run_sequence();
    int steps, r;
    send_item(OP_START, 8'($urandom_range(0, 255)));
    steps = $urandom_range(4, 30);
    for (int k = 0; k < steps; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      send_burst(pass_pat, pass_len);
      else if (r < 50) send_burst(fail_pat, fail_len);
      else if (r < 62) send_item(OP_BYTE, alpha[$urandom_range(0, 2)]);
      else if (r < 72) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      else if (r < 90) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      else if (r < 94) send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
      else if (r < 98) send_item(OP_START, 8'($urandom_range(0, 255)));
      else             wait_idle(0);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_BYTE;
    sent   = 0;
    phases = 0;
    calm   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: items while idle are ignored, zero byte passes
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_START, 8'h00);
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_BYTE, 8'h00);

    // pass and fail share a byte: pass wins; zero timeout ends on first tick
    wait_idle(SETTLE);
    write_config(64'hAA, 4'd1, 64'hAA, 4'd1, '0);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'hAA);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h55);
    send_item(OP_TICK, 8'h00);

    // two-byte pass, three-byte fail, simple matching after a mismatch
    wait_idle(SETTLE);
    write_config(64'h4B4F, 4'd2, 64'h525245, 4'd3, 32'd2);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h4F);
    send_item(OP_BYTE, 8'h4F);
    send_item(OP_BYTE, 8'h4B);
    send_item(OP_BYTE, 8'h45);
    send_item(OP_BYTE, 8'h52);
    send_item(OP_BYTE, 8'h52);

    // pass disabled, fail length clamped to eight, timeout never reached
    wait_idle(SETTLE);
    write_config('1, 4'd0, '1, 4'd15, '1);
    send_item(OP_START, 8'h00);
    for (int i = 0; i < MAX_PATTERN_DEF; i++) send_item(OP_BYTE, 8'hFF);

    // random phases
    while (sent < ITEM_TARGET) begin
      wait_idle(SETTLE);
      calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 3; i++)
        alpha[i] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(8'h41, 8'h44));
      write_config(make_pattern(), pick_len(), make_pattern(), pick_len(), pick_timeout());
      repeat ($urandom_range(3, 8)) run_sequence();
    end

    // drain and let any stray verdict show up
    calm = 1'b1;
    wait_idle(8);

    $display("run: %0d input transfers (%0d acted on) over %0d register settings",
             sent, live_items, phases);
    $display("verdicts seen: %0d pass, %0d fail, %0d timeout",
             pass_count, fail_count, timeout_count);
    if (mismatches == 0 && pending == 0) begin
      $display("dual_response_matcher_timeout_unit_tb: clean");
    end else begin
      $display("dual_response_matcher_timeout_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/drmt_pkg.sv
hdl/drmt_track.sv
hdl/dual_response_matcher_timeout_unit.sv
hdl/drmt_checker.sv
bench/drmt_verdict_checker.sv
bench/dual_response_matcher_timeout_unit_tb.sv
